### design/u8dec_pkg.sv
// Package: constants and the decode result type shared by the UTF-8 console decoder.
`timescale 1ns / 1ps
package u8dec_pkg;

    localparam logic [15:0] QMARK    = 16'h003F;
    localparam logic [15:0] BOM      = 16'hFEFF;
    localparam logic [15:0] CR       = 16'h000D;
    localparam logic [15:0] LF       = 16'h000A;

    localparam logic [7:0]  LEAD2_LO = 8'hC2;
    localparam logic [7:0]  LEAD3_LO = 8'hE0;
    localparam logic [7:0]  LEAD3_HI = 8'hEF;

    // Number of output beats one input byte produces.
    localparam logic [1:0]  EMIT_NONE = 2'd0;
    localparam logic [1:0]  EMIT_ONE  = 2'd1;
    localparam logic [1:0]  EMIT_CRLF = 2'd2;

    typedef struct packed {
        logic [1:0]  emit;       // EMIT_NONE, EMIT_ONE or EMIT_CRLF
        logic [15:0] unit;       // code unit for EMIT_ONE
        logic [7:0]  lead_next;  // next pending lead byte
        logic [7:0]  mid_next;   // next pending middle byte
    } t_dec;

endpackage

### design/u8dec_core.sv
// Combinational decode of one byte against the pending lead and middle bytes.
`timescale 1ns / 1ps
module u8dec_core (
    input  logic [7:0]      i_byte,
    input  logic [7:0]      i_lead,
    input  logic [7:0]      i_mid,
    output u8dec_pkg::t_dec o_dec
);

    logic [15:0] ch;
    logic        has_ch;

    always_comb begin
        ch     = u8dec_pkg::QMARK;
        has_ch = 1'b1;
        o_dec.lead_next = 8'h00;
        o_dec.mid_next  = 8'h00;

        if (i_byte inside {[8'h00:8'h7F]}) begin
            // ASCII; an open sequence is dropped and shown as '?'
            if (i_lead == 8'h00) begin
                ch = {8'h00, i_byte};
            end
        end else if (i_byte inside {[8'h80:8'hBF]}) begin
            if (i_lead == 8'h00) begin
                ch = u8dec_pkg::QMARK;
            end else if (i_lead < u8dec_pkg::LEAD3_LO) begin
                ch = {5'b0, i_lead[4:0], i_byte[5:0]};
            end else if (i_mid == 8'h00) begin
                // hold the middle byte of a three-byte sequence
                has_ch          = 1'b0;
                o_dec.lead_next = i_lead;
                o_dec.mid_next  = i_byte;
            end else begin
                ch = {i_lead[3:0], i_mid[5:0], i_byte[5:0]};
            end
        end else if (i_byte inside {[u8dec_pkg::LEAD2_LO:u8dec_pkg::LEAD3_HI]}) begin
            // new lead replaces any open sequence silently
            has_ch          = 1'b0;
            o_dec.lead_next = i_byte;
        end

        o_dec.unit = ch;
        if (!has_ch || ch == u8dec_pkg::BOM) begin
            o_dec.emit = u8dec_pkg::EMIT_NONE;
        end else if (ch == u8dec_pkg::LF) begin
            o_dec.emit = u8dec_pkg::EMIT_CRLF;
        end else begin
            o_dec.emit = u8dec_pkg::EMIT_ONE;
        end
    end

endmodule

### design/utf8_to_ucs2_console_decoder.sv
// Top level: UTF-8 byte stream to UCS-2 console code units.
`timescale 1ns / 1ps
// Datapath: a byte lands in the input register on the beat it is taken, and its first
//   code unit is decoded there and loaded into the result register, which feeds the output.
// Throughput: one byte per cycle while the output side keeps up; a newline (plain or
//   decoded) takes two beats, CR then LF; a following byte that emits waits for the LF.
// Reset (synchronous, active low): clear both pending bytes, the input and output
//   valid flags and the queued LF; payload registers are not reset.
module utf8_to_ucs2_console_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_byte_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_code_unit,
    output logic        o_last_of_run
);

    // Input register
    logic        r_in_vld, n_in_vld;
    logic [7:0]  r_in_byte, n_in_byte;
    // Decoder state: open lead byte and held middle byte
    logic [7:0]  r_lead, n_lead;
    logic [7:0]  r_mid, n_mid;
    // Result register plus a queued LF for the second beat of a newline
    logic        r_out_vld, n_out_vld;
    logic [15:0] r_out_unit, n_out_unit;
    logic        r_out_last, n_out_last;
    logic        r_lf_pend, n_lf_pend;

    u8dec_pkg::t_dec dec;
    logic            out_take;   // output beat completes this cycle
    logic            out_free;   // result register can load a new unit
    logic            s1_adv;     // the byte in the input register retires

    u8dec_core u_core (
        .i_byte (r_in_byte),
        .i_lead (r_lead),
        .i_mid  (r_mid),
        .o_dec  (dec)
    );

    assign out_take = r_out_vld && i_out_ready;
    // The queued LF has priority on the result register.
    assign out_free = !r_lf_pend && (!r_out_vld || i_out_ready);
    // A byte that emits nothing retires without waiting on the output side.
    assign s1_adv   = r_in_vld && (dec.emit == u8dec_pkg::EMIT_NONE || out_free);

    assign o_in_ready    = !r_in_vld || s1_adv;
    assign o_out_valid   = r_out_vld;
    assign o_code_unit   = r_out_unit;
    assign o_last_of_run = r_out_last;

    always_comb begin
        n_in_vld   = r_in_vld;
        n_in_byte  = r_in_byte;
        n_lead     = r_lead;
        n_mid      = r_mid;
        n_out_vld  = r_out_vld;
        n_out_unit = r_out_unit;
        n_out_last = r_out_last;
        n_lf_pend  = r_lf_pend;

        // Drop the delivered beat.
        if (out_take) begin
            n_out_vld = 1'b0;
        end

        // Advance the queued LF into the result register.
        if (r_lf_pend && out_take) begin
            n_out_vld  = 1'b1;
            n_out_unit = u8dec_pkg::LF;
            n_out_last = 1'b1;
            n_lf_pend  = 1'b0;
        end

        // Retire the held byte: update state and load its first unit.
        if (s1_adv) begin
            n_lead = dec.lead_next;
            n_mid  = dec.mid_next;
            case (dec.emit)
                u8dec_pkg::EMIT_ONE: begin
                    n_out_vld  = 1'b1;
                    n_out_unit = dec.unit;
                    n_out_last = 1'b1;
                end
                u8dec_pkg::EMIT_CRLF: begin
                    n_out_vld  = 1'b1;
                    n_out_unit = u8dec_pkg::CR;
                    n_out_last = 1'b0;
                    n_lf_pend  = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // Take a new byte.
        if (o_in_ready) begin
            n_in_vld  = i_in_valid;
            n_in_byte = i_byte_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_lead    <= 8'h00;
            r_mid     <= 8'h00;
            r_out_vld <= 1'b0;
            r_lf_pend <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_lead    <= n_lead;
            r_mid     <= n_mid;
            r_out_vld <= n_out_vld;
            r_lf_pend <= n_lf_pend;
        end
        r_in_byte  <= n_in_byte;
        r_out_unit <= n_out_unit;
        r_out_last <= n_out_last;
    end

    // A queued LF always sits behind a CR that is not the last of its run.
    a_lf_behind_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lf_pend |-> (r_out_vld && !r_out_last && r_out_unit == u8dec_pkg::CR))
        else $error("queued LF without a CR beat in front");

    // A beat that is not last must be followed by the queued LF.
    a_notlast_has_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_last) |-> r_lf_pend)
        else $error("non-last beat with no LF queued");

    // Once the CR is taken, the LF is offered next and closes the run.
    a_lf_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lf_pend && out_take) |=>
            (o_out_valid && o_last_of_run && o_code_unit == u8dec_pkg::LF))
        else $error("LF did not follow CR");

    // A middle byte is only held under a three-byte lead.
    a_mid_needs_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mid != 8'h00) |-> (r_lead >= u8dec_pkg::LEAD3_LO && r_mid[7:6] == 2'b10))
        else $error("middle byte held without a three-byte lead");

endmodule

### tb/tb.sv
// Testbench for the UTF-8 to UCS-2 console decoder: directed and random bytes against a predictor.
`timescale 1ns / 1ps
module tb;

    // Byte class boundaries of UTF-8: below CONT_BASE is ASCII, below
    // LEAD_BASE is a continuation byte, the rest are lead bytes.
    localparam logic [7:0] CONT_BASE  = 8'h80;
    localparam logic [7:0] LEAD_BASE  = 8'hC0;
    localparam logic [7:0] NEWLINE    = 8'h0A;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         PHASE_BYTES    = 400;

    typedef struct packed {
        logic [15:0] unit;
        logic        last;
    } t_unit_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_byte_in;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_code_unit;
    logic        o_last_of_run;

    utf8_to_ucs2_console_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_byte_in     (i_byte_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_code_unit   (o_code_unit),
        .o_last_of_run (o_last_of_run)
    );

    // Bytes waiting to be offered, and code units the decoder owes us.
    logic [7:0]  pending_bytes[$];
    t_unit_beat  expected_units[$];

    // Shadow copy of the decoder's open sequence.
    logic [7:0]  shadow_lead = 8'h00;
    logic [7:0]  shadow_mid  = 8'h00;

    int          sender_idle_pct   = 0;
    int          receiver_idle_pct = 0;
    int          bytes_queued      = 0;
    int          err_count         = 0;
    int          stall_cycles      = 0;
    bit          in_taken          = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Queue the code units one decoded character produces: drop a BOM,
    // expand a newline to CR then LF with LF marked last.
    task automatic owe_char(input logic [15:0] ch);
        begin
            if (ch == u8dec_pkg::BOM) begin
                return;
            end
            if (ch == u8dec_pkg::LF) begin
                expected_units.push_back('{unit: u8dec_pkg::CR, last: 1'b0});
                expected_units.push_back('{unit: u8dec_pkg::LF, last: 1'b1});
            end else begin
                expected_units.push_back('{unit: ch, last: 1'b1});
            end
        end
    endtask

    // Advance the shadow decoder by one accepted byte.
    task automatic decode_byte(input logic [7:0] b);
        logic [15:0] ch;
        begin
            if (b < CONT_BASE) begin
                if (shadow_lead == 8'h00) begin
                    owe_char({8'h00, b});
                end else begin
                    // ASCII breaks the open sequence; the byte itself is lost.
                    shadow_lead = 8'h00;
                    shadow_mid  = 8'h00;
                    owe_char(u8dec_pkg::QMARK);
                end
            end else if (b < LEAD_BASE) begin
                if (shadow_lead == 8'h00) begin
                    owe_char(u8dec_pkg::QMARK);
                end else if (shadow_lead < u8dec_pkg::LEAD3_LO) begin
                    ch = {5'd0, shadow_lead[4:0], b[5:0]};
                    shadow_lead = 8'h00;
                    shadow_mid  = 8'h00;
                    owe_char(ch);
                end else if (shadow_mid == 8'h00) begin
                    shadow_mid = b;
                end else begin
                    ch = {shadow_lead[3:0], shadow_mid[5:0], b[5:0]};
                    shadow_lead = 8'h00;
                    shadow_mid  = 8'h00;
                    owe_char(ch);
                end
            end else if (b >= u8dec_pkg::LEAD2_LO && b <= u8dec_pkg::LEAD3_HI) begin
                // A fresh lead silently replaces any open sequence.
                shadow_lead = b;
                shadow_mid  = 8'h00;
            end else begin
                shadow_lead = 8'h00;
                shadow_mid  = 8'h00;
                owe_char(u8dec_pkg::QMARK);
            end
        end
    endtask

    task automatic queue_byte(input logic [7:0] b);
        begin
            pending_bytes.push_back(b);
            bytes_queued++;
        end
    endtask

    function automatic logic [7:0] rnd_cont();
        return CONT_BASE | 8'($urandom_range(63));
    endfunction

    // C0, C1 or F0..FF: lead bytes that never open a sequence.
    function automatic logic [7:0] rnd_bad_lead();
        int r;
        r = $urandom_range(17);
        if (r < 2) begin
            return LEAD_BASE + 8'(r);
        end
        return 8'hF0 + 8'(r - 2);
    endfunction

    // Fill the byte queue with mostly well-formed text, plus broken
    // sequences and raw noise, until at least n_bytes more bytes are queued.
    task automatic queue_random_text(input int n_bytes);
        int         target;
        int         kind;
        logic [7:0] lead;
        begin
            target = bytes_queued + n_bytes;
            while (bytes_queued < target) begin
                kind = $urandom_range(99);
                if (kind < 25) begin
                    if ($urandom_range(7) == 0) begin
                        queue_byte(NEWLINE);
                    end else begin
                        queue_byte(8'($urandom_range(8'h7F)));
                    end
                end else if (kind < 45) begin
                    queue_byte(8'($urandom_range(8'hDF, 8'hC2)));
                    queue_byte(rnd_cont());
                end else if (kind < 70) begin
                    case ($urandom_range(9))
                        0: begin
                            queue_byte(8'hEF); queue_byte(8'hBB); queue_byte(8'hBF);
                        end
                        1: begin
                            queue_byte(8'hE0); queue_byte(8'h80); queue_byte(8'h8A);
                        end
                        default: begin
                            queue_byte(8'($urandom_range(8'hEF, 8'hE0)));
                            queue_byte(rnd_cont());
                            queue_byte(rnd_cont());
                        end
                    endcase
                end else if (kind < 80) begin
                    queue_byte(8'($urandom_range(255)));
                end else if (kind < 90) begin
                    // Truncated sequence, cut off by ASCII or by another lead.
                    lead = 8'($urandom_range(8'hEF, 8'hC2));
                    queue_byte(lead);
                    if (lead >= u8dec_pkg::LEAD3_LO && $urandom_range(1) == 1) begin
                        queue_byte(rnd_cont());
                    end
                    case ($urandom_range(2))
                        0:       queue_byte(8'($urandom_range(8'h7F)));
                        1:       queue_byte(8'($urandom_range(8'hEF, 8'hC2)));
                        default: queue_byte(rnd_bad_lead());
                    endcase
                end else if ($urandom_range(1) == 0) begin
                    queue_byte(rnd_cont());
                end else begin
                    queue_byte(rnd_bad_lead());
                end
            end
        end
    endtask

    // Driver: change inputs on the falling edge; hold a beat until taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                i_in_valid <= 1'b1;
                i_byte_in  <= pending_bytes.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        in_taken = 1'b0;
        i_out_ready <= i_rst_n && ($urandom_range(99) >= receiver_idle_pct);
    end

    // Monitor: on each rising edge, predict for a taken input beat and
    // check a taken output beat against the oldest owed code unit.
    always @(posedge i_clk) begin : monitor
        t_unit_beat want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                decode_byte(i_byte_in);
                in_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_units.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected beat: expected none, got unit %h last %b",
                             $time, o_code_unit, o_last_of_run);
                end else begin
                    want = expected_units.pop_front();
                    if (o_code_unit !== want.unit) begin
                        err_count++;
                        $display("%0t: code_unit mismatch: expected %h, got %h",
                                 $time, want.unit, o_code_unit);
                    end
                    if (o_last_of_run !== want.last) begin
                        err_count++;
                        $display("%0t: last_of_run mismatch: expected %b, got %b",
                                 $time, want.last, o_last_of_run);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with work outstanding but no beat on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles <= 0;
            end else if (i_in_valid || pending_bytes.size() != 0
                         || expected_units.size() != 0) begin
                if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
                    $display("Test completed with failures");
                    $finish;
                end else begin
                    stall_cycles <= stall_cycles + 1;
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_byte_in   = 8'h00;
        i_out_ready = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase one: sender idles lightly, receiver stalls often.
        sender_idle_pct   = 19;
        receiver_idle_pct = 63;

        // Directed: byte extremes, newline, a stray continuation, bad leads.
        queue_byte(8'h00); queue_byte(8'h7F); queue_byte(NEWLINE);
        queue_byte(8'h80); queue_byte(8'hC0); queue_byte(8'hFF);
        // Two-byte extremes U+0080 and U+07FF.
        queue_byte(8'hC2); queue_byte(8'h80);
        queue_byte(8'hDF); queue_byte(8'hBF);
        // Overlong three-byte newline, then a BOM to swallow, then U+FFFF.
        queue_byte(8'hE0); queue_byte(8'h80); queue_byte(8'h8A);
        queue_byte(8'hEF); queue_byte(8'hBB); queue_byte(8'hBF);
        queue_byte(8'hEF); queue_byte(8'hBF); queue_byte(8'hBF);
        // ASCII cutting into an open sequence.
        queue_byte(8'hC2); queue_byte(8'h41);
        // New lead replaces an open one, then completes.
        queue_byte(8'hE1); queue_byte(8'hC3); queue_byte(8'hA9);
        // Invalid lead after a held middle byte.
        queue_byte(8'hE2); queue_byte(8'h82); queue_byte(8'hF5);

        queue_random_text(PHASE_BYTES);
        while (pending_bytes.size() != 0) @(posedge i_clk);

        // Phase two: swap the idle rates.
        sender_idle_pct   = 63;
        receiver_idle_pct = 19;
        queue_random_text(PHASE_BYTES);
        while (pending_bytes.size() != 0) @(posedge i_clk);

        // Phase three: full rate on both sides.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        queue_random_text(PHASE_BYTES);

        while (pending_bytes.size() != 0 || i_in_valid || expected_units.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && expected_units.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
design/u8dec_pkg.sv
design/u8dec_core.sv
design/utf8_to_ucs2_console_decoder.sv
tb/tb.sv
